FILE: rtl/core/ihla_pkg.sv
// Package for the implicit-list heap allocator.
// Holds widths, codes and the beat and configuration types shared by the allocator files.
// Depends on nothing.
package ihla_pkg;

	localparam int HEAP_BYTES = 4096;
	localparam int SLOT_COUNT = HEAP_BYTES / 8;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int OFF_W = SLOT_W + 1;
	localparam int HDR_W = SLOT_W + 1;

	localparam int CFG_W = 13;
	localparam int REQ_W = 13;
	localparam int PAY_W = 12;
	localparam int USED_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int MIN_HEAP_BYTES = 16;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST = 1'b1;

	typedef struct packed {
		logic operation;
		logic [REQ_W-1:0] request_bytes;
		logic [PAY_W-1:0] payload_offset;
	} req_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [PAY_W-1:0] result_offset;
		logic [USED_W-1:0] used_bytes;
	} rsp_beat_t;

	typedef struct packed {
		logic [CFG_W-1:0] heap_bytes;
		logic [CFG_W-1:0] max_request;
		logic reinit;
	} ihla_cfg_t;

endpackage

FILE: rtl/core/implicit_list_heap_allocator_unit.sv
// Top level of the implicit-list first-fit heap allocator.
// Holds the configuration registers and the response register; uses ihla_pkg and ihla_ctrl.
//
// Channel   Direction  Handshake          Beat
// req       in         req_valid/stall    ihla_pkg::req_beat_t
// rsp       out        rsp_valid/stall    ihla_pkg::rsp_beat_t
// cfg       in         cfg_valid/ready    cfg_index, cfg_data
//
// An allocate passes through a check, a walk that reads headers up to the first fit, a split
// step for a fit with a remainder, and an output state; a beat refused before the walk goes
// from the check to the output state; a free walks to its block and merges a free successor.
// The single header RAM port reads one header per cycle and bounds the walk.
// After reset and each heap size write, the first header is written in idle; req stalls.
// A new beat is accepted while a response waits in the output register.
module implicit_list_heap_allocator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  ihla_pkg::req_beat_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output ihla_pkg::rsp_beat_t rsp_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ihla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ihla_pkg::CFG_W-1:0] cfg_data
);

	logic [ihla_pkg::CFG_W-1:0] heap_q;
	logic [ihla_pkg::CFG_W-1:0] max_req_q;
	logic [ihla_pkg::CFG_W-1:0] heap_wr;
	logic cfg_wr;
	ihla_pkg::ihla_cfg_t cfg;
	logic res_valid;
	logic res_take;
	ihla_pkg::rsp_beat_t res;
	logic rsp_valid_q;
	ihla_pkg::rsp_beat_t rsp_data_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_comb begin
		heap_wr = {cfg_data[ihla_pkg::CFG_W-1:3], 3'b000};
		if (heap_wr < ihla_pkg::CFG_W'(ihla_pkg::MIN_HEAP_BYTES)) begin
			heap_wr = ihla_pkg::CFG_W'(ihla_pkg::MIN_HEAP_BYTES);
		end else if (heap_wr > ihla_pkg::CFG_W'(ihla_pkg::HEAP_BYTES)) begin
			heap_wr = ihla_pkg::CFG_W'(ihla_pkg::HEAP_BYTES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= ihla_pkg::CFG_W'(ihla_pkg::HEAP_BYTES);
			max_req_q <= ihla_pkg::CFG_W'(4096);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				ihla_pkg::CFG_HEAP_SIZE: heap_q <= heap_wr;
				ihla_pkg::CFG_MAX_REQUEST: max_req_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.heap_bytes = heap_q;
	assign cfg.max_request = max_req_q;
	assign cfg.reinit = cfg_wr && (cfg_index == ihla_pkg::CFG_HEAP_SIZE);

	ihla_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_take(res_take),
		.res(res)
	);

	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_data_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_data_q;

endmodule

FILE: rtl/core/ihla_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module ihla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/ihla_ctrl.sv
// Allocator sequencer: walks the header list in the RAM, one header per cycle,
// and performs allocate, split, free and merge. Depends on ihla_pkg and ihla_ram.
module ihla_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  ihla_pkg::ihla_cfg_t cfg,
	input  logic req_valid,
	output logic req_stall,
	input  ihla_pkg::req_beat_t req_data,
	output logic res_valid,
	input  logic res_take,
	output ihla_pkg::rsp_beat_t res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_MERGE,
		S_SPLIT,
		S_OUT
	} state_t;

	state_t state_q, state_d;
	logic init_q, init_d;
	logic op_q, op_d;
	logic [ihla_pkg::REQ_W-1:0] req_q, req_d;
	logic [ihla_pkg::PAY_W-1:0] pay_q, pay_d;
	logic [ihla_pkg::SLOT_W-1:0] need_q, need_d;
	logic [ihla_pkg::SLOT_W-1:0] size_q, size_d;
	logic [ihla_pkg::OFF_W-1:0] off_q, off_d;
	logic [ihla_pkg::USED_W-1:0] used_q, used_d;
	ihla_pkg::rsp_beat_t res_q, res_d;

	logic ram_we;
	logic [ihla_pkg::SLOT_W-1:0] ram_addr;
	logic [ihla_pkg::HDR_W-1:0] ram_wdata;
	logic [ihla_pkg::HDR_W-1:0] ram_rdata;

	logic [ihla_pkg::OFF_W-1:0] heap_slots;
	logic [ihla_pkg::SLOT_W-1:0] hdr_size;
	logic hdr_free;
	logic [ihla_pkg::OFF_W-1:0] nxt;
	logic [ihla_pkg::REQ_W:0] need_up;
	logic [ihla_pkg::REQ_W+1:0] total;
	logic [ihla_pkg::OFF_W-1:0] target;
	logic [ihla_pkg::OFF_W-1:0] merged;
	logic [ihla_pkg::OFF_W+2:0] alloc_off;
	logic fit_exact, fit_split;
	logic finish;
	logic [1:0] fin_status;
	logic [ihla_pkg::PAY_W-1:0] fin_offset;

	ihla_ram #(
		.WIDTH(ihla_pkg::HDR_W),
		.DEPTH(ihla_pkg::SLOT_COUNT)
	) u_hdr_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign heap_slots = cfg.heap_bytes[ihla_pkg::CFG_W-1:3];
	assign hdr_size = ram_rdata[ihla_pkg::HDR_W-1:1];
	assign hdr_free = ram_rdata[0];
	assign nxt = off_q + ihla_pkg::OFF_W'(1) + {1'b0, hdr_size};
	assign need_up = {1'b0, req_q} + (ihla_pkg::REQ_W + 1)'(7);
	assign total = {2'b00, used_q} + (ihla_pkg::REQ_W + 2)'(8)
		+ {1'b0, need_up[ihla_pkg::REQ_W:3], 3'b000};
	assign target = {1'b0, pay_q[ihla_pkg::PAY_W-1:3] - ihla_pkg::SLOT_W'(1)};
	assign merged = {1'b0, size_q} + ihla_pkg::OFF_W'(1) + {1'b0, hdr_size};
	assign alloc_off = {off_q + ihla_pkg::OFF_W'(1), 3'b000};
	assign fit_exact = (need_q == hdr_size);
	assign fit_split = ({1'b0, need_q} + ihla_pkg::OFF_W'(2)) <= {1'b0, hdr_size};

	assign req_stall = (state_q != S_IDLE) || init_q;
	assign res_valid = (state_q == S_OUT);
	assign res = res_q;

	always_comb begin
		state_d = state_q;
		init_d = init_q;
		op_d = op_q;
		req_d = req_q;
		pay_d = pay_q;
		need_d = need_q;
		size_d = size_q;
		off_d = off_q;
		used_d = used_q;
		res_d = res_q;
		ram_we = 1'b0;
		ram_addr = off_q[ihla_pkg::SLOT_W-1:0];
		ram_wdata = '0;
		finish = 1'b0;
		fin_status = ihla_pkg::ST_DONE;
		fin_offset = '0;

		unique case (state_q)
			S_IDLE: begin
				if (init_q) begin
					ram_we = 1'b1;
					ram_addr = '0;
					ram_wdata = {ihla_pkg::SLOT_W'(heap_slots - ihla_pkg::OFF_W'(1)), 1'b1};
					used_d = ihla_pkg::USED_W'(8);
					init_d = 1'b0;
				end else if (req_valid) begin
					op_d = req_data.operation;
					req_d = req_data.request_bytes;
					pay_d = req_data.payload_offset;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				off_d = '0;
				ram_addr = '0;
				if (op_q == ihla_pkg::OP_ALLOC) begin
					if (req_q == '0 || req_q > cfg.max_request) begin
						finish = 1'b1;
						fin_status = ihla_pkg::ST_REFUSED;
					end else if (total > {2'b00, cfg.heap_bytes}) begin
						finish = 1'b1;
						fin_status = ihla_pkg::ST_NO_SPACE;
					end else begin
						need_d = need_up[ihla_pkg::SLOT_W+2:3];
						state_d = S_WALK;
					end
				end else begin
					if (pay_q[ihla_pkg::PAY_W-1:3] == '0 || pay_q[2:0] != 3'b000) begin
						finish = 1'b1;
						fin_status = ihla_pkg::ST_IGNORED;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (op_q == ihla_pkg::OP_ALLOC) begin
					if (hdr_free && (fit_exact || fit_split)) begin
						ram_we = 1'b1;
						ram_wdata = {need_q, 1'b0};
						used_d = used_q + ihla_pkg::USED_W'({need_q, 3'b000});
						if (fit_split) begin
							size_d = hdr_size;
							state_d = S_SPLIT;
						end else begin
							finish = 1'b1;
							fin_offset = alloc_off[ihla_pkg::PAY_W-1:0];
						end
					end else if (nxt >= heap_slots) begin
						finish = 1'b1;
						fin_status = ihla_pkg::ST_NO_SPACE;
					end else begin
						off_d = nxt;
						ram_addr = nxt[ihla_pkg::SLOT_W-1:0];
					end
				end else begin
					if (off_q < target) begin
						if (nxt >= heap_slots) begin
							finish = 1'b1;
							fin_status = ihla_pkg::ST_IGNORED;
						end else begin
							off_d = nxt;
							ram_addr = nxt[ihla_pkg::SLOT_W-1:0];
						end
					end else if (off_q == target && !hdr_free) begin
						size_d = hdr_size;
						if (nxt < heap_slots) begin
							ram_addr = nxt[ihla_pkg::SLOT_W-1:0];
							state_d = S_MERGE;
						end else begin
							ram_we = 1'b1;
							ram_wdata = {hdr_size, 1'b1};
							used_d = used_q - ihla_pkg::USED_W'({hdr_size, 3'b000});
							finish = 1'b1;
						end
					end else begin
						finish = 1'b1;
						fin_status = ihla_pkg::ST_IGNORED;
					end
				end
			end
			S_MERGE: begin
				ram_we = 1'b1;
				finish = 1'b1;
				if (hdr_free) begin
					ram_wdata = {merged[ihla_pkg::SLOT_W-1:0], 1'b1};
					used_d = used_q - ihla_pkg::USED_W'(8) - ihla_pkg::USED_W'({size_q, 3'b000});
				end else begin
					ram_wdata = {size_q, 1'b1};
					used_d = used_q - ihla_pkg::USED_W'({size_q, 3'b000});
				end
			end
			S_SPLIT: begin
				ram_we = 1'b1;
				ram_addr = ihla_pkg::SLOT_W'(off_q + ihla_pkg::OFF_W'(1) + {1'b0, need_q});
				ram_wdata = {size_q - need_q - ihla_pkg::SLOT_W'(1), 1'b1};
				used_d = used_q + ihla_pkg::USED_W'(8);
				finish = 1'b1;
				fin_offset = alloc_off[ihla_pkg::PAY_W-1:0];
			end
			S_OUT: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (finish) begin
			res_d.status = fin_status;
			res_d.result_offset = fin_offset;
			res_d.used_bytes = used_d;
			state_d = S_OUT;
		end
		if (cfg.reinit) begin
			init_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_q <= 1'b1;
			used_q <= ihla_pkg::USED_W'(8);
		end else begin
			state_q <= state_d;
			init_q <= init_d;
			used_q <= used_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		req_q <= req_d;
		pay_q <= pay_d;
		need_q <= need_d;
		size_q <= size_d;
		off_q <= off_d;
		res_q <= res_d;
	end

`ifndef SYNTHESIS
	a_used_within_heap: assert property (@(posedge clk) disable iff (!arst_n)
		!init_q |-> used_q <= cfg.heap_bytes)
		else $error("Used byte count exceeds the heap size.");

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> state_q == S_CHECK)
		else $error("Accepted beat did not start a check.");

	a_walk_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_MERGE || state_q == S_SPLIT) |-> off_q < heap_slots)
		else $error("Header walk left the heap.");

	a_alloc_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && op_q == ihla_pkg::OP_ALLOC && res_q.status == ihla_pkg::ST_DONE)
		|-> res_q.result_offset != '0)
		else $error("Successful allocation returned a null offset.");

	a_fail_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && res_q.status != ihla_pkg::ST_DONE) |-> res_q.result_offset == '0)
		else $error("Failed step returned an offset.");
`endif

endmodule

FILE: dv/implicit_list_heap_allocator_unit_tb.sv
// Testbench for implicit_list_heap_allocator_unit: directed and random allocate and free beats.
// A scoreboard class predicts each response from its own copy of the heap headers.
// Depends on ihla_pkg and the allocator RTL.
module implicit_list_heap_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int PHASES = 10;
	localparam int PHASE_BEATS = 180;

	class heap_scoreboard;
		logic [12:0] headers [0:511];
		int used;
		int heap_bytes;
		int max_req;
		ihla_pkg::rsp_beat_t expected_replies[$];
		int errors;
		int placed;
		int released;
		int turned_away;

		function new();
			heap_bytes = ihla_pkg::HEAP_BYTES;
			max_req = 4096;
			errors = 0;
			placed = 0;
			released = 0;
			turned_away = 0;
			reinit();
		endfunction

		function void reinit();
			for (int i = 0; i < 512; i++)
				headers[i] = '0;
			set_block(0, heap_bytes - 8, 1'b1);
			used = 8;
		endfunction

		function int size_at(int off);
			return int'(headers[(off >> 3) & 511]) & ~7;
		endfunction

		function bit block_free(int off);
			return headers[(off >> 3) & 511][0];
		endfunction

		function void set_block(int off, int size, bit is_free);
			headers[(off >> 3) & 511] = 13'(size & ~7) | 13'(is_free);
		endfunction

		function int block_after(int off);
			return off + 8 + size_at(off);
		endfunction

		function void write_register(logic [ihla_pkg::CFG_IDX_W-1:0] idx, int value);
			int v;
			if (idx == ihla_pkg::CFG_HEAP_SIZE) begin
				v = value & 'h1FF8;
				if (v < ihla_pkg::MIN_HEAP_BYTES)
					v = ihla_pkg::MIN_HEAP_BYTES;
				if (v > ihla_pkg::HEAP_BYTES)
					v = ihla_pkg::HEAP_BYTES;
				heap_bytes = v;
				reinit();
			end else begin
				max_req = value & 'h1FFF;
			end
		endfunction

		function logic [1:0] allocate(int req, output int where);
			int need;
			int off;
			int sz;
			bit exact;
			bit split;
			where = 0;
			if (req == 0 || req > max_req)
				return ihla_pkg::ST_REFUSED;
			need = (req + 7) & ~7;
			if (used + 8 + need > heap_bytes)
				return ihla_pkg::ST_NO_SPACE;
			off = 0;
			while (off < heap_bytes) begin
				sz = size_at(off);
				exact = (need == sz);
				split = (need + 16 <= sz);
				if (block_free(off) && (exact || split)) begin
					set_block(off, need, 1'b0);
					used += need;
					if (split) begin
						set_block(off + 8 + need, sz - need - 8, 1'b1);
						used += 8;
					end
					where = off + 8;
					return ihla_pkg::ST_DONE;
				end
				off = block_after(off);
			end
			return ihla_pkg::ST_NO_SPACE;
		endfunction

		function logic [1:0] free_block(int pay);
			int target;
			int off;
			int sz;
			int nxt;
			if (pay < 8)
				return ihla_pkg::ST_IGNORED;
			target = pay - 8;
			off = 0;
			while (off < heap_bytes && off < target)
				off = block_after(off);
			if (off != target || off >= heap_bytes || block_free(off))
				return ihla_pkg::ST_IGNORED;
			sz = size_at(off);
			nxt = block_after(off);
			if (nxt < heap_bytes && block_free(nxt)) begin
				set_block(off, sz + 8 + size_at(nxt), 1'b1);
				used -= 8 + sz;
			end else begin
				set_block(off, sz, 1'b1);
				used -= sz;
			end
			return ihla_pkg::ST_DONE;
		endfunction

		function ihla_pkg::rsp_beat_t note_request(ihla_pkg::req_beat_t b);
			ihla_pkg::rsp_beat_t r;
			int where;
			r = '0;
			where = 0;
			if (b.operation == ihla_pkg::OP_ALLOC)
				r.status = allocate(int'(b.request_bytes), where);
			else
				r.status = free_block(int'(b.payload_offset));
			r.result_offset = ihla_pkg::PAY_W'(where);
			r.used_bytes = ihla_pkg::USED_W'(used);
			if (r.status != ihla_pkg::ST_DONE)
				turned_away++;
			else if (b.operation == ihla_pkg::OP_ALLOC)
				placed++;
			else
				released++;
			expected_replies.push_back(r);
			return r;
		endfunction

		function void check_response(ihla_pkg::rsp_beat_t got);
			ihla_pkg::rsp_beat_t want;
			if (expected_replies.size() == 0) begin
				$error("Response beat %h arrived with nothing outstanding.", got);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.result_offset !== want.result_offset) begin
				$error("result_offset: expected %0d, got %0d", want.result_offset,
					got.result_offset);
				errors++;
			end
			if (got.used_bytes !== want.used_bytes) begin
				$error("used_bytes: expected %0d, got %0d", want.used_bytes, got.used_bytes);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ihla_pkg::req_beat_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ihla_pkg::rsp_beat_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ihla_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ihla_pkg::CFG_W-1:0] cfg_data = '0;

	heap_scoreboard sb;
	int live[$];
	int freed[$];
	bit quiet = 1'b0;
	int stall_left = 0;
	int cycle_count = 0;

	int heap_writes[PHASES] = '{4096, 256, 0, 8191, 1000, 64, 4095, 520, -1, 4096};
	int max_writes[PHASES] = '{4096, 64, 1, 8191, 200, 4096, 512, 8, 2048, 4096};

	implicit_list_heap_allocator_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("implicit_list_heap_allocator_unit verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			sb.check_response(rsp_data);
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 3);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	function automatic int gap_length();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic ihla_pkg::req_beat_t alloc_beat(int n);
		ihla_pkg::req_beat_t b;
		b.operation = ihla_pkg::OP_ALLOC;
		b.request_bytes = ihla_pkg::REQ_W'(n);
		b.payload_offset = ihla_pkg::PAY_W'($urandom);
		return b;
	endfunction

	function automatic ihla_pkg::req_beat_t free_beat(int pay);
		ihla_pkg::req_beat_t b;
		b.operation = ihla_pkg::OP_FREE;
		b.request_bytes = ihla_pkg::REQ_W'($urandom);
		b.payload_offset = ihla_pkg::PAY_W'(pay);
		return b;
	endfunction

	function automatic ihla_pkg::req_beat_t random_beat(int alloc_pct);
		int r;
		int lim;
		int top;
		r = $urandom_range(0, 99);
		lim = (sb.max_req > 4096) ? 4096 : sb.max_req;
		if (lim < 1)
			lim = 1;
		top = sb.heap_bytes / 4;
		if (top > lim)
			top = lim;
		if (r < alloc_pct || (r < 85 && live.size() == 0)) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				return alloc_beat($urandom_range(1, top));
			if (r < 9)
				return alloc_beat($urandom_range(1, lim));
			case ($urandom_range(0, 3))
				0: return alloc_beat(0);
				1: return alloc_beat(sb.max_req);
				2: return alloc_beat(sb.max_req + 1);
				default: return alloc_beat($urandom_range(0, 8191));
			endcase
		end
		if (r < 85)
			return free_beat(live[$urandom_range(0, live.size() - 1)]);
		case ($urandom_range(0, 3))
			0: return free_beat(0);
			1: begin
				if (freed.size() != 0)
					return free_beat(freed[$urandom_range(0, freed.size() - 1)]);
				return free_beat($urandom_range(0, 4095));
			end
			2: begin
				if (live.size() != 0)
					return free_beat(live[$urandom_range(0, live.size() - 1)]
						+ $urandom_range(1, 7));
				return free_beat($urandom_range(0, 15));
			end
			default: return free_beat($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic send(ihla_pkg::req_beat_t b);
		ihla_pkg::rsp_beat_t r;
		int gap;
		int idx;
		gap = gap_length();
		idx = -1;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= b;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		r = sb.note_request(b);
		if (r.status == ihla_pkg::ST_DONE) begin
			if (b.operation == ihla_pkg::OP_ALLOC) begin
				live.push_back(int'(r.result_offset));
			end else begin
				foreach (live[i])
					if (live[i] == int'(b.payload_offset))
						idx = i;
				if (idx >= 0)
					live.delete(idx);
				freed.push_back(int'(b.payload_offset));
				if (freed.size() > 8)
					void'(freed.pop_front());
			end
		end
	endtask

	task automatic write_reg(logic [ihla_pkg::CFG_IDX_W-1:0] idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ihla_pkg::CFG_W'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_register(idx, value & 'h1FFF);
	endtask

	task automatic wait_idle();
		while (sb.expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int alloc_pct;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(alloc_beat(0));
		send(alloc_beat(4097));
		send(alloc_beat(8191));
		send(alloc_beat(4088));
		send(alloc_beat(4080));
		send(free_beat(0));
		send(free_beat(4));
		send(free_beat(4095));
		send(alloc_beat(1));
		send(alloc_beat(8));
		send(free_beat(12));
		send(free_beat(8));
		send(free_beat(8));
		send(alloc_beat(4056));
		send(free_beat(24));
		send(free_beat(40));
		send(alloc_beat(16));
		send(free_beat(40));
		send(free_beat(24));
		send(alloc_beat(8));
		send(free_beat(8));
		req_valid <= 1'b0;
		live.delete();
		freed.delete();

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			quiet = (p % 4 == 2);
			if (heap_writes[p] >= 0) begin
				write_reg(ihla_pkg::CFG_HEAP_SIZE, heap_writes[p]);
				live.delete();
				freed.delete();
			end
			write_reg(ihla_pkg::CFG_MAX_REQUEST, max_writes[p]);
			cfg_valid <= 1'b0;
			alloc_pct = $urandom_range(35, 60);
			repeat (PHASE_BEATS) send(random_beat(alloc_pct));
			req_valid <= 1'b0;
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Covered %0d placements, %0d releases and %0d refused or ignored beats",
			sb.placed, sb.released, sb.turned_away);
		$display("over %0d register settings, with %0d mismatches.", PHASES, sb.errors);
		if (sb.errors == 0)
			$display("implicit_list_heap_allocator_unit verification clean");
		else
			$display("implicit_list_heap_allocator_unit verification failed");
		$finish;
	end

endmodule
